// ----- hw/rtl/acov_pkg.sv -----
// shared constants and types for the ancestry tract bin coverage block
// no dependencies; used by acov_div and ancestry_tract_bin_coverage under hw/rtl
package acov_pkg;

    localparam int POS_FRAC_BITS = 16;
    localparam int POS_W = POS_FRAC_BITS + 1;
    localparam logic [POS_W-1:0] ONE_POS = POS_W'(1) << POS_FRAC_BITS;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_JUNCTION = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam int ANC_FIELD_W = 7;
    localparam int BIN_FIELD_W = 8;
    localparam int SHIFT_W = 4;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd4;

    localparam int SUM_W = 30;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam int IND_W = 13;
    localparam logic [IND_W-1:0] MAX_INDIVIDUALS = 13'd4096;
    localparam int DIV_W = IND_W + 1;

    localparam int DEF_MAX_ANCESTORS = 64;
    localparam int DEF_MAX_BINS = 256;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BIN_RD,
        ST_BIN_WR,
        ST_Q_RD,
        ST_Q_START,
        ST_Q_DIV,
        ST_OUT
    } state_t;

endpackage

// ----- hw/rtl/acov_ram.sv -----
// generic single port ram with registered read
// no dependencies
module acov_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 16384
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ----- hw/rtl/acov_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// depends on acov_pkg for the sum and divisor widths
module acov_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [acov_pkg::SUM_W-1:0]   dividend,
    input  logic [acov_pkg::DIV_W-1:0]   divisor,
    output logic                         done,
    output logic [acov_pkg::SUM_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(acov_pkg::SUM_W + 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [acov_pkg::DIV_W-1:0]  rem_reg, rem_next;
    logic [acov_pkg::DIV_W-1:0]  dsr_reg, dsr_next;
    logic [acov_pkg::SUM_W-1:0]  work_reg, work_next;
    logic [acov_pkg::DIV_W:0]    trial;
    logic                        ge;

    assign trial = {rem_reg, work_reg[acov_pkg::SUM_W-1]};
    assign ge = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        work_next = work_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            work_next = dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? acov_pkg::DIV_W'(trial - {1'b0, dsr_reg})
                           : acov_pkg::DIV_W'(trial);
            work_next = {work_reg[acov_pkg::SUM_W-2:0], ge};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(acov_pkg::SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        work_reg <= work_next;
    end

    assign done = done_reg;
    assign quotient = work_reg;

endmodule

// ----- hw/rtl/ancestry_tract_bin_coverage.sv -----
// top level of the ancestry tract bin coverage block: sequencer, tract state and bin update
// depends on acov_pkg, acov_ram and acov_div
//
// input words arrive on in_valid/in_ready with kind, position, ancestor and query_bin.
// a junction closes the interval opened by the previous junction and, if that one
// has an in-range ancestor and positive length, adds each spanned bin's covered
// fraction to the sum store by read-modify-write, one bin at a time (at most 2^bin_shift).
// a query reads one sum and divides it by twice the individual count in a
// one-bit-per-cycle divider; a query out of range, or with no individuals, returns zero.
// a clear resets the tract state and makes a clearing pass over the store.
// in_ready is high only while the sequencer is idle.
// results leave on out_valid/out_ready from an output register; the next word is
// taken while a result waits, and a finished query holds until the register frees.
// the user must write bin_shift through cfg_we/cfg_wdata only while idle; not enforced.
// after reset the store is cleared, one entry a cycle, over all
// MAX_ANCESTORS * MAX_BINS entries (16384 by default) before in_ready rises.
module ancestry_tract_bin_coverage #(
    parameter int MAX_ANCESTORS = acov_pkg::DEF_MAX_ANCESTORS,
    parameter int MAX_BINS = acov_pkg::DEF_MAX_BINS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [acov_pkg::SHIFT_W-1:0]               cfg_wdata,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic [acov_pkg::KIND_W-1:0]                kind,
    input  logic [acov_pkg::POS_W-1:0]                 position,
    input  logic signed [acov_pkg::ANC_FIELD_W-1:0]    ancestor,
    input  logic [acov_pkg::BIN_FIELD_W-1:0]           query_bin,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [acov_pkg::POS_W-1:0]                 coverage,
    output logic signed [acov_pkg::ANC_FIELD_W-1:0]    highest_ancestor,
    output logic [acov_pkg::IND_W-1:0]                 individual_count
);

    localparam int DEPTH = MAX_ANCESTORS * MAX_BINS;
    localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int ANC_W = MAX_ANCESTORS > 1 ? $clog2(MAX_ANCESTORS) : 1;
    localparam int BIN_W = MAX_BINS > 1 ? $clog2(MAX_BINS) : 1;
    localparam int BIN_LOG = $clog2(MAX_BINS + 1) - 1;
    localparam int MAX_SHIFT = BIN_LOG < acov_pkg::POS_FRAC_BITS ? BIN_LOG
                                                                : acov_pkg::POS_FRAC_BITS;
    localparam int SH_W = 5;
    localparam int MAG_W = acov_pkg::ANC_FIELD_W - 1;
    localparam int POS_W = acov_pkg::POS_W;
    localparam int SUM_W = acov_pkg::SUM_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    acov_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0]                        clr_addr_reg;
    logic [acov_pkg::SHIFT_W-1:0]             bin_shift_reg;
    logic [POS_W-1:0]                         prev_pos_reg;
    logic signed [acov_pkg::ANC_FIELD_W-1:0]  prev_anc_reg;
    logic                                     second_reg;
    logic [acov_pkg::IND_W-1:0]               ind_reg;
    logic signed [acov_pkg::ANC_FIELD_W-1:0]  max_anc_reg;

    logic [ANC_W-1:0]                         work_anc_reg;
    logic [BIN_W-1:0]                         bin_reg;
    logic [BIN_W-1:0]                         end_bin_reg;
    logic [POS_W-1:0]                         lo_reg;
    logic [POS_W-1:0]                         hi_reg;
    logic [POS_W-1:0]                         frac_reg;
    logic [POS_W-1:0]                         cov_reg;

    logic                                     out_valid_reg;
    logic [POS_W-1:0]                         out_cov_reg;
    logic signed [acov_pkg::ANC_FIELD_W-1:0]  out_high_reg;
    logic [acov_pkg::IND_W-1:0]               out_ind_reg;

    logic                      accept;
    logic [POS_W-1:0]          pos_c;
    logic [SH_W-1:0]           eff_s;
    logic [SH_W-1:0]           wsh;
    logic [POS_W-1:0]          bin_w;
    logic                      prev_anc_ok;
    logic                      interval_ok;
    logic                      query_ok;
    logic [POS_W-1:0]          blo;
    logic [POS_W-1:0]          bhi;
    logic [POS_W-1:0]          seg_l;
    logic [POS_W-1:0]          seg_h;
    logic [SUM_W:0]            sum_add;
    logic [SUM_W-1:0]          sum_sat;
    logic [SUM_W-1:0]          quot;
    logic                      div_done;

    logic                      ram_we;
    logic                      ram_re;
    logic [ADDR_W-1:0]         ram_addr;
    logic [SUM_W-1:0]          ram_wdata;
    logic [SUM_W-1:0]          ram_rdata;
    logic                      div_start;
    logic                      out_load;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == acov_pkg::ST_IDLE);

    assign pos_c = (position > acov_pkg::ONE_POS) ? acov_pkg::ONE_POS : position;
    assign eff_s = (32'(bin_shift_reg) > MAX_SHIFT) ? SH_W'(MAX_SHIFT)
                                                    : SH_W'(bin_shift_reg);
    assign wsh = SH_W'(acov_pkg::POS_FRAC_BITS) - eff_s;
    assign bin_w = acov_pkg::ONE_POS >> eff_s;

    assign prev_anc_ok = !prev_anc_reg[MAG_W]
                         && (32'(prev_anc_reg[MAG_W-1:0]) < MAX_ANCESTORS);
    assign interval_ok = prev_anc_ok && (pos_c > prev_pos_reg);
    assign query_ok = !ancestor[MAG_W]
                      && (32'(ancestor[MAG_W-1:0]) < MAX_ANCESTORS)
                      && ((query_bin >> eff_s) == '0)
                      && (ind_reg != '0);

    // overlap of the open interval with the current bin
    assign blo = POS_W'(bin_reg) << wsh;
    assign bhi = blo + bin_w;
    assign seg_l = (lo_reg > blo) ? lo_reg : blo;
    assign seg_h = (hi_reg < bhi) ? hi_reg : bhi;

    assign sum_add = {1'b0, ram_rdata} + (SUM_W + 1)'(frac_reg);
    assign sum_sat = sum_add[SUM_W] ? acov_pkg::SUM_MAX : sum_add[SUM_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            acov_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = acov_pkg::ST_IDLE;
                end
            end
            acov_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (kind == acov_pkg::KIND_JUNCTION)
                    begin
                        if (interval_ok)
                        begin
                            state_next = acov_pkg::ST_BIN_RD;
                        end
                    end
                    else if (kind == acov_pkg::KIND_QUERY)
                    begin
                        state_next = query_ok ? acov_pkg::ST_Q_RD : acov_pkg::ST_OUT;
                    end
                    else if (kind == acov_pkg::KIND_CLEAR)
                    begin
                        state_next = acov_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        state_next = acov_pkg::ST_IDLE;
                    end
                end
            end
            acov_pkg::ST_BIN_RD:
            begin
                state_next = acov_pkg::ST_BIN_WR;
            end
            acov_pkg::ST_BIN_WR:
            begin
                state_next = (bin_reg == end_bin_reg) ? acov_pkg::ST_IDLE
                                                      : acov_pkg::ST_BIN_RD;
            end
            acov_pkg::ST_Q_RD:
            begin
                state_next = acov_pkg::ST_Q_START;
            end
            acov_pkg::ST_Q_START:
            begin
                state_next = acov_pkg::ST_Q_DIV;
            end
            acov_pkg::ST_Q_DIV:
            begin
                if (div_done)
                begin
                    state_next = acov_pkg::ST_OUT;
                end
            end
            acov_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = acov_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = acov_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_wdata = sum_sat;
        ram_addr  = ADDR_W'(ADDR_W'(work_anc_reg) * ADDR_W'(MAX_BINS)) + ADDR_W'(bin_reg);
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            acov_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                ram_addr  = clr_addr_reg;
            end
            acov_pkg::ST_BIN_RD:  ram_re = 1'b1;
            acov_pkg::ST_BIN_WR:  ram_we = 1'b1;
            acov_pkg::ST_Q_RD:    ram_re = 1'b1;
            acov_pkg::ST_Q_START: div_start = 1'b1;
            acov_pkg::ST_OUT:     out_load = !out_valid_reg || out_ready;
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= acov_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            bin_shift_reg <= acov_pkg::SHIFT_RESET;
            prev_pos_reg  <= '0;
            prev_anc_reg  <= '1;
            second_reg    <= 1'b0;
            ind_reg       <= '0;
            max_anc_reg   <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                bin_shift_reg <= cfg_wdata;
            end
            if (state_reg == acov_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (accept && kind == acov_pkg::KIND_JUNCTION)
            begin
                prev_pos_reg <= pos_c;
                prev_anc_reg <= ancestor;
                if (ancestor > max_anc_reg)
                begin
                    max_anc_reg <= ancestor;
                end
                if (ancestor == -7'sd1)
                begin
                    second_reg <= !second_reg;
                    if (second_reg && ind_reg < acov_pkg::MAX_INDIVIDUALS)
                    begin
                        ind_reg <= ind_reg + acov_pkg::IND_W'(1);
                    end
                end
            end
            else if (accept && kind == acov_pkg::KIND_CLEAR)
            begin
                clr_addr_reg <= '0;
                prev_pos_reg <= '0;
                prev_anc_reg <= '1;
                second_reg   <= 1'b0;
                ind_reg      <= '0;
                max_anc_reg  <= '1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && kind == acov_pkg::KIND_JUNCTION)
        begin
            work_anc_reg <= ANC_W'(prev_anc_reg[MAG_W-1:0]);
            lo_reg       <= prev_pos_reg;
            hi_reg       <= pos_c;
            bin_reg      <= BIN_W'(prev_pos_reg >> wsh);
            end_bin_reg  <= BIN_W'(POS_W'(pos_c - POS_W'(1)) >> wsh);
        end
        else if (accept && kind == acov_pkg::KIND_QUERY)
        begin
            work_anc_reg <= ANC_W'(ancestor[MAG_W-1:0]);
            bin_reg      <= BIN_W'(query_bin);
            cov_reg      <= '0;
        end
        if (state_reg == acov_pkg::ST_BIN_RD)
        begin
            frac_reg <= POS_W'((seg_h - seg_l) << eff_s);
        end
        if (state_reg == acov_pkg::ST_BIN_WR)
        begin
            bin_reg <= bin_reg + BIN_W'(1);
        end
        if (state_reg == acov_pkg::ST_Q_DIV && div_done)
        begin
            cov_reg <= (quot > SUM_W'(acov_pkg::ONE_POS)) ? acov_pkg::ONE_POS
                                                         : quot[POS_W-1:0];
        end
        if (out_load)
        begin
            out_cov_reg  <= cov_reg;
            out_high_reg <= max_anc_reg;
            out_ind_reg  <= ind_reg;
        end
    end

    acov_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    acov_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ram_rdata),
        .divisor  ({ind_reg, 1'b0}),
        .done     (div_done),
        .quotient (quot)
    );

    assign out_valid = out_valid_reg;
    assign coverage = out_cov_reg;
    assign highest_ancestor = out_high_reg;
    assign individual_count = out_ind_reg;

endmodule

// ----- tb/acov_checker.sv -----
// checker for ancestry_tract_bin_coverage: follows bin_shift writes and accepted words,
// predicts each query result and compares it field by field with the output channel
// depends on acov_pkg
module acov_checker #(
    parameter int ANCESTORS = acov_pkg::DEF_MAX_ANCESTORS,
    parameter int BINS = acov_pkg::DEF_MAX_BINS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [acov_pkg::SHIFT_W-1:0]               cfg_wdata,
    input  logic                                       in_valid,
    input  logic                                       in_ready,
    input  logic [acov_pkg::KIND_W-1:0]                kind,
    input  logic [acov_pkg::POS_W-1:0]                 position,
    input  logic signed [acov_pkg::ANC_FIELD_W-1:0]    ancestor,
    input  logic [acov_pkg::BIN_FIELD_W-1:0]           query_bin,
    input  logic                                       out_valid,
    input  logic                                       out_ready,
    input  logic [acov_pkg::POS_W-1:0]                 coverage,
    input  logic signed [acov_pkg::ANC_FIELD_W-1:0]    highest_ancestor,
    input  logic [acov_pkg::IND_W-1:0]                 individual_count,
    output int                                         errors,
    output int                                         pending,
    output int                                         results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [acov_pkg::POS_W-1:0]              coverage;
        logic signed [acov_pkg::ANC_FIELD_W-1:0] highest;
        logic [acov_pkg::IND_W-1:0]              count;
    } tract_report_t;

    logic [acov_pkg::SUM_W-1:0] tract_sum [ANCESTORS * BINS];
    longint open_pos;
    int open_anc;
    bit second_copy;
    int pairs_seen;
    int top_anc;
    int bin_shift;
    tract_report_t report_queue [$];

    function automatic int active_shift();
        int s;
        s = 0;
        while (s < bin_shift && s < acov_pkg::POS_FRAC_BITS && (1 << (s + 1)) <= BINS)
            s++;
        return s;
    endfunction

    function automatic void wipe_tracts();
        foreach (tract_sum[i])
            tract_sum[i] = '0;
        open_pos = 0;
        open_anc = -1;
        second_copy = 1'b0;
        pairs_seen = 0;
        top_anc = -1;
    endfunction

    function automatic void add_tract(int anc, longint lo, longint hi);
        int s;
        int b;
        longint width;
        longint blo;
        longint l;
        longint h;
        longint total;
        if (anc < 0 || anc >= ANCESTORS || hi <= lo)
            return;
        s = active_shift();
        width = longint'(acov_pkg::ONE_POS) >> s;
        for (b = 0; b < (1 << s); b++)
        begin
            blo = b * width;
            l = (lo > blo) ? lo : blo;
            h = (hi < blo + width) ? hi : blo + width;
            if (h > l)
            begin
                total = longint'(tract_sum[anc * BINS + b]) + ((h - l) << s);
                if (total > longint'(acov_pkg::SUM_MAX))
                    tract_sum[anc * BINS + b] = acov_pkg::SUM_MAX;
                else
                    tract_sum[anc * BINS + b] = total[acov_pkg::SUM_W-1:0];
            end
        end
    endfunction

    function automatic void take_junction(longint pos, int anc);
        if (open_anc >= 0)
            add_tract(open_anc, open_pos, pos);
        if (anc > top_anc)
            top_anc = anc;
        open_pos = pos;
        open_anc = anc;
        if (anc == -1)
        begin
            if (second_copy)
            begin
                if (pairs_seen < int'(acov_pkg::MAX_INDIVIDUALS))
                    pairs_seen++;
                second_copy = 1'b0;
            end
            else
            begin
                second_copy = 1'b1;
            end
        end
    endfunction

    function automatic tract_report_t answer_query(int anc, int bin);
        tract_report_t r;
        longint cov;
        cov = 0;
        if (anc >= 0 && anc < ANCESTORS && bin < (1 << active_shift()) && pairs_seen > 0)
        begin
            cov = longint'(tract_sum[anc * BINS + bin]) / (2 * longint'(pairs_seen));
            if (cov > longint'(acov_pkg::ONE_POS))
                cov = longint'(acov_pkg::ONE_POS);
        end
        r.coverage = cov[acov_pkg::POS_W-1:0];
        r.highest = top_anc[acov_pkg::ANC_FIELD_W-1:0];
        r.count = pairs_seen[acov_pkg::IND_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tract_report_t want;
        longint pos;
        if (!rst_n)
        begin
            wipe_tracts();
            bin_shift = int'(acov_pkg::SHIFT_RESET);
            report_queue.delete();
            errors = 0;
            pending = 0;
            results_checked = 0;
        end
        else
        begin
            if (cfg_we)
                bin_shift = int'(cfg_wdata);
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (report_queue.size() == 0)
                begin
                    errors++;
                    $error("unexpected result: coverage %0d highest_ancestor %0d %s %0d",
                           coverage, highest_ancestor, "individual_count",
                           individual_count);
                end
                else
                begin
                    want = report_queue.pop_front();
                    if (coverage !== want.coverage)
                    begin
                        errors++;
                        $error("coverage: expected %0d, got %0d", want.coverage, coverage);
                    end
                    if (highest_ancestor !== want.highest)
                    begin
                        errors++;
                        $error("highest_ancestor: expected %0d, got %0d",
                               want.highest, highest_ancestor);
                    end
                    if (individual_count !== want.count)
                    begin
                        errors++;
                        $error("individual_count: expected %0d, got %0d",
                               want.count, individual_count);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                pos = longint'(position);
                if (pos > longint'(acov_pkg::ONE_POS))
                    pos = longint'(acov_pkg::ONE_POS);
                case (kind)
                    acov_pkg::KIND_JUNCTION: take_junction(pos, int'(ancestor));
                    acov_pkg::KIND_QUERY:
                        report_queue = {report_queue,
                                        answer_query(int'(ancestor), int'(query_bin))};
                    acov_pkg::KIND_CLEAR: wipe_tracts();
                    default: ;
                endcase
            end
            pending = report_queue.size();
        end
    end

endmodule

// ----- tb/ancestry_tract_bin_coverage_tb.sv -----
// testbench top for ancestry_tract_bin_coverage: drives junction, query and clear words
// and bin_shift writes with random idling on both channels, then gives the verdict
// depends on acov_pkg, the block under hw/rtl and acov_checker
module ancestry_tract_bin_coverage_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [acov_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CHROM_END = -1;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int LONG_HOLD = 400;
    localparam int SETTLE_CYCLES = 600;
    localparam int PHASE_WORDS = 76;
    localparam int TAIL_CHROMOSOMES = 40;
    localparam int TAIL_QUERY_EVERY = 10;
    localparam int MAX_RANDOM_CLEARS = 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [acov_pkg::SHIFT_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [acov_pkg::KIND_W-1:0] kind = acov_pkg::KIND_JUNCTION;
    logic [acov_pkg::POS_W-1:0] position = '0;
    logic signed [acov_pkg::ANC_FIELD_W-1:0] ancestor = '0;
    logic [acov_pkg::BIN_FIELD_W-1:0] query_bin = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [acov_pkg::POS_W-1:0] coverage;
    logic signed [acov_pkg::ANC_FIELD_W-1:0] highest_ancestor;
    logic [acov_pkg::IND_W-1:0] individual_count;

    int errors;
    int pending;
    int results_checked;
    int cycle_count = 0;
    bit quiet = 1'b0;
    bit long_hold_req = 1'b0;
    int shift_now = int'(acov_pkg::SHIFT_RESET);
    int scored_words = 0;
    int junctions_sent = 0;
    int queries_sent = 0;
    int clears_sent = 0;
    int settings_used = 1;

    ancestry_tract_bin_coverage dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .position(position),
        .ancestor(ancestor),
        .query_bin(query_bin),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .coverage(coverage),
        .highest_ancestor(highest_ancestor),
        .individual_count(individual_count)
    );

    acov_checker tract_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .position(position),
        .ancestor(ancestor),
        .query_bin(query_bin),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .coverage(coverage),
        .highest_ancestor(highest_ancestor),
        .individual_count(individual_count),
        .errors(errors),
        .pending(pending),
        .results_checked(results_checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stalls, one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic [acov_pkg::KIND_W-1:0] k, input int p, input int a,
                             input int b);
        bit taken;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        position <= acov_pkg::POS_W'(p);
        ancestor <= acov_pkg::ANC_FIELD_W'(a);
        query_bin <= acov_pkg::BIN_FIELD_W'(b);
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        if (k != KIND_UNUSED)
            scored_words++;
        if (k == acov_pkg::KIND_JUNCTION)
            junctions_sent++;
        else if (k == acov_pkg::KIND_QUERY)
            queries_sent++;
        else if (k == acov_pkg::KIND_CLEAR)
            clears_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_shift(input int v);
        cfg_we <= 1'b1;
        cfg_wdata <= acov_pkg::SHIFT_W'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        shift_now = v;
        settings_used++;
    endtask

    function automatic int pick_ancestor(input int pool);
        int roll;
        roll = $urandom_range(0, 31);
        if (roll == 0)
            return -int'($urandom_range(2, 64));
        if (roll < 3)
            return int'($urandom_range(0, 63));
        return int'($urandom_range(0, pool - 1));
    endfunction

    task automatic lay_chromosome(input int pool);
        int segs;
        int i;
        int p;
        segs = $urandom_range(1, 6);
        p = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8192)) : 0;
        for (i = 0; i < segs; i++)
        begin
            send_word(acov_pkg::KIND_JUNCTION, p, pick_ancestor(pool), $urandom);
            p = p + int'($urandom_range(0, 2 * 65536 / segs));
            if (p > int'(acov_pkg::ONE_POS))
                p = int'(acov_pkg::ONE_POS);
        end
        case ($urandom_range(0, 7))
            0: p = int'(acov_pkg::ONE_POS) + int'($urandom_range(0, 65535));
            1: p = p;
            default: p = int'(acov_pkg::ONE_POS);
        endcase
        send_word(acov_pkg::KIND_JUNCTION, p, CHROM_END, $urandom);
    endtask

    task automatic ask_some(input int pool);
        int anc;
        int bin;
        if ($urandom_range(0, 7) == 0)
        begin
            anc = int'($urandom_range(0, 127)) - 64;
            bin = $urandom_range(0, 255);
        end
        else
        begin
            anc = $urandom_range(0, pool - 1);
            bin = $urandom_range(0, (1 << ((shift_now > 8) ? 8 : shift_now)) - 1);
        end
        send_word(acov_pkg::KIND_QUERY, $urandom, anc, bin);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_word(KIND_UNUSED, $urandom, $urandom, $urandom);
            1: send_word(acov_pkg::KIND_JUNCTION, $urandom, $urandom, $urandom);
            default: send_word(acov_pkg::KIND_JUNCTION, $urandom_range(0, 32768),
                               pick_ancestor(8), $urandom);
        endcase
    endtask

    initial
    begin
        int phase_shift [10];
        int ph;
        int pool;
        int start_words;
        int roll;
        int i;
        phase_shift = '{0, 8, 15, 1, 2, 3, 5, 6, 7, 12};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at the reset bin setting
        send_word(acov_pkg::KIND_QUERY, 0, 0, 0);
        send_word(acov_pkg::KIND_JUNCTION, 0, 63, 0);
        send_word(acov_pkg::KIND_JUNCTION, 'h8000, 0, 0);
        send_word(acov_pkg::KIND_JUNCTION, 'h1FFFF, CHROM_END, 0);
        send_word(acov_pkg::KIND_JUNCTION, 'h4000, 5, 0);
        send_word(acov_pkg::KIND_JUNCTION, 'h2000, 5, 0);
        send_word(acov_pkg::KIND_JUNCTION, 'h2000, -64, 0);
        send_word(acov_pkg::KIND_JUNCTION, 'h9000, 3, 0);
        send_word(acov_pkg::KIND_JUNCTION, int'(acov_pkg::ONE_POS), CHROM_END, 0);
        send_word(acov_pkg::KIND_QUERY, 0, 63, 0);
        send_word(acov_pkg::KIND_QUERY, 0, 0, 15);
        send_word(acov_pkg::KIND_QUERY, 0, 3, 16);
        send_word(acov_pkg::KIND_QUERY, 0, CHROM_END, 0);
        send_word(acov_pkg::KIND_QUERY, 'h1FFFF, -64, 255);
        send_word(acov_pkg::KIND_QUERY, 0, 0, 255);
        send_word(acov_pkg::KIND_QUERY, 0, 3, 8);
        send_word(KIND_UNUSED, 'h1FFFF, CHROM_END, 255);
        send_word(acov_pkg::KIND_JUNCTION, 0, 7, 0);
        send_word(acov_pkg::KIND_JUNCTION, int'(acov_pkg::ONE_POS), CHROM_END, 0);
        send_word(acov_pkg::KIND_QUERY, 0, 7, 3);
        send_word(acov_pkg::KIND_CLEAR, 0, 0, 0);
        send_word(acov_pkg::KIND_QUERY, 0, 7, 3);

        for (ph = 0; ph < 10; ph++)
        begin
            settle();
            set_shift(phase_shift[ph]);
            pool = (ph == 5) ? 64 : int'($urandom_range(1, 8));
            start_words = scored_words;
            // closes the interval left open before the bin setting changed
            send_word(acov_pkg::KIND_JUNCTION, int'(acov_pkg::ONE_POS), CHROM_END, $urandom);
            if (ph == 1)
            begin
                long_hold_req = 1'b1;
                repeat (6) ask_some(pool);
            end
            while (scored_words - start_words < PHASE_WORDS)
            begin
                roll = $urandom_range(0, 15);
                if (roll < 9)
                begin
                    lay_chromosome(pool);
                    if ($urandom_range(0, 1) == 0)
                        ask_some(pool);
                end
                else if (roll < 13)
                    ask_some(pool);
                else if (roll < 15)
                    send_noise();
                else if (clears_sent < MAX_RANDOM_CLEARS)
                    send_word(acov_pkg::KIND_CLEAR, $urandom, $urandom, $urandom);
                else
                    ask_some(pool);
            end
            send_word(acov_pkg::KIND_JUNCTION, $urandom_range(0, 65535), pick_ancestor(pool),
                      $urandom);
            ask_some(pool);
        end

        // last part without idling: full-length chromosomes on one ancestor, one bin
        settle();
        quiet = 1'b1;
        set_shift(0);
        send_word(acov_pkg::KIND_CLEAR, 0, 0, 0);
        for (i = 0; i < TAIL_CHROMOSOMES; i++)
        begin
            send_word(acov_pkg::KIND_JUNCTION, 0, 9, 0);
            send_word(acov_pkg::KIND_JUNCTION, int'(acov_pkg::ONE_POS), CHROM_END, 0);
            if (i % TAIL_QUERY_EVERY == TAIL_QUERY_EVERY - 1)
                send_word(acov_pkg::KIND_QUERY, 0, 9, 0);
        end
        send_word(acov_pkg::KIND_QUERY, 0, 9, 0);
        send_word(acov_pkg::KIND_QUERY, 0, 8, 0);
        send_word(acov_pkg::KIND_QUERY, 0, 9, 1);
        settle();

        $display("covered %0d words: %0d junctions, %0d queries, %0d clears, %0d bin settings",
                 scored_words, junctions_sent, queries_sent, clears_sent, settings_used);
        $display("checked %0d coverage results, full-bin coverage of one ancestor included",
                 results_checked);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
